// ----- hdl/aabb_pkg.sv -----
// shared types and constants of the static box collision resolver
package aabb_pkg;

   // field widths
   localparam int POS_W  = 24;  // position and velocity
   localparam int OFF_W  = 21;  // centre offset
   localparam int HALF_W = 20;  // half extent
   localparam int CTR_W  = 25;  // box centre, position plus offset
   localparam int DIFF_W = 26;  // centre difference
   localparam int HSUM_W = 21;  // sum of two half extents
   localparam int PEN_W  = 27;  // penetration and corrected position before saturation

   // saturation limits of a position, at adder width and at centre width
   localparam logic signed [PEN_W-1:0] PEN_POS_MAX = 27'sd8388607;
   localparam logic signed [PEN_W-1:0] PEN_POS_MIN = -27'sd8388608;
   localparam logic signed [CTR_W-1:0] CTR_POS_MAX = 25'sd8388607;
   localparam logic signed [CTR_W-1:0] CTR_POS_MIN = -25'sd8388608;

   // command codes
   typedef enum logic [1:0] {
      CMD_WRITE   = 2'd0,
      CMD_CLEAR   = 2'd1,
      CMD_RESOLVE = 2'd2
   } cmd_type;

   // controller states
   typedef enum logic [2:0] {
      ST_WIPE,
      ST_IDLE,
      ST_PRIME,
      ST_DIFF,
      ST_PEN,
      ST_UPD,
      ST_DONE
   } state_type;

   // one static box table entry
   typedef struct packed {
      logic                     vld;
      logic signed [CTR_W-1:0]  cx;
      logic signed [CTR_W-1:0]  cy;
      logic        [HALF_W-1:0] hx;
      logic        [HALF_W-1:0] hy;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // commands from the controller to the datapath
   typedef struct packed {
      logic wipe;    // write an invalid entry at the walk index
      logic wr;      // write or clear the requested slot
      logic wr_vld;  // valid bit of that write
      logic load;    // capture a dynamic box
      logic diff;    // centre differences and half extent sums
      logic pen;     // penetrations
      logic upd;     // push out and update the dynamic box
   } dp_cmd_type;

endpackage

// ----- hdl/aabb_ram.sv -----
// generic single write port ram with registered read
module aabb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/aabb_ctrl.sv -----
// controller state machine: table clearing pass, commands and slot walk
module aabb_ctrl import aabb_pkg::*; #(
   parameter int STATIC_SLOTS = 64,
   localparam int CW = $clog2(STATIC_SLOTS + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [1:0]    req_cmd,
   input  logic [5:0]    req_slot,
   output logic          busy,
   output logic          rsp_valid,
   output dp_cmd_type    dp_cmd,
   output logic [CW-1:0] idx
);

   state_type     state_ff, state_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          accept;
   logic          slot_ok;
   logic          wipe_last;
   logic          walk_last;

   assign accept    = start && (state_ff == ST_IDLE);
   assign slot_ok   = (32'(req_slot) < STATIC_SLOTS);
   assign wipe_last = (idx_ff == CW'(STATIC_SLOTS - 1));
   assign walk_last = (idx_ff == CW'(STATIC_SLOTS));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_WIPE:  if (wipe_last) state_in = ST_IDLE;
         ST_IDLE:  if (accept && req_cmd == CMD_RESOLVE) state_in = ST_PRIME;
         ST_PRIME: state_in = ST_DIFF;
         ST_DIFF:  state_in = ST_PEN;
         ST_PEN:   state_in = ST_UPD;
         ST_UPD:   state_in = walk_last ? ST_DONE : ST_DIFF;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // slot counter: clearing pass and walk
   always_comb begin
      idx_in = idx_ff;
      unique case (state_ff)
         ST_WIPE: idx_in = wipe_last ? '0 : idx_ff + 1'b1;
         ST_IDLE: idx_in = '0;
         ST_DIFF: idx_in = idx_ff + 1'b1;
         default: idx_in = idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_WIPE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   // outputs
   always_comb begin
      dp_cmd    = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_WIPE:  dp_cmd.wipe = 1'b1;
         ST_IDLE: begin
            busy          = 1'b0;
            dp_cmd.wr     = accept && slot_ok &&
                            (req_cmd == CMD_WRITE || req_cmd == CMD_CLEAR);
            dp_cmd.wr_vld = (req_cmd == CMD_WRITE);
            dp_cmd.load   = accept && (req_cmd == CMD_RESOLVE);
         end
         ST_PRIME: ;
         ST_DIFF:  dp_cmd.diff = 1'b1;
         ST_PEN:   dp_cmd.pen = 1'b1;
         ST_UPD:   dp_cmd.upd = 1'b1;
         ST_DONE:  rsp_valid = 1'b1;
         default:  ;
      endcase
   end

   assign idx = idx_ff;

endmodule

// ----- hdl/aabb_dp.sv -----
// datapath: static box table, penetration and push-out of the dynamic box
module aabb_dp import aabb_pkg::*; #(
   parameter int STATIC_SLOTS = 64,
   localparam int CW = $clog2(STATIC_SLOTS + 1),
   localparam int AW = (STATIC_SLOTS > 1) ? $clog2(STATIC_SLOTS) : 1
) (
   input  logic                     clock,
   input  dp_cmd_type               dp_cmd,
   input  logic [CW-1:0]            idx,
   input  logic [5:0]               req_slot,
   input  logic signed [POS_W-1:0]  req_pos_x,
   input  logic signed [POS_W-1:0]  req_pos_y,
   input  logic signed [OFF_W-1:0]  req_off_x,
   input  logic signed [OFF_W-1:0]  req_off_y,
   input  logic        [HALF_W-1:0] req_half_x,
   input  logic        [HALF_W-1:0] req_half_y,
   input  logic signed [POS_W-1:0]  req_vel_x,
   input  logic signed [POS_W-1:0]  req_vel_y,
   input  logic                     req_ground_in,
   output logic signed [POS_W-1:0]  rsp_new_pos_x,
   output logic signed [POS_W-1:0]  rsp_new_pos_y,
   output logic signed [POS_W-1:0]  rsp_new_vel_x,
   output logic signed [POS_W-1:0]  rsp_new_vel_y,
   output logic                     rsp_on_ground,
   output logic                     rsp_collided
);

   // table port signals
   entry_type         wr_entry, rd_entry;
   logic [AW-1:0]     wr_addr;
   logic              wr_en;
   logic signed [CTR_W-1:0] ctr_x_in, ctr_y_in;
   logic signed [CTR_W-1:0] ofs_x, ofs_y;

   // dynamic box state
   logic signed [POS_W-1:0]  px_ff, py_ff, vx_ff, vy_ff;
   logic                     gnd_ff, hit_ff;
   logic        [HALF_W-1:0] hx_ff, hy_ff;
   logic signed [CTR_W-1:0]  qx_ff, qy_ff;
   logic signed [CTR_W-1:0]  qx_max_ff, qx_min_ff, qy_max_ff, qy_min_ff;

   // walk pipeline registers
   logic signed [DIFF_W-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic        [HSUM_W-1:0] hsx_ff, hsy_ff, hsx_in, hsy_in;
   logic                     vld_a_ff, vld_b_ff;
   logic signed [PEN_W-1:0]  penx_ff, peny_ff, penx_in, peny_in;
   logic                     sx_ff, sy_ff;

   // push-out signals
   logic                     overlap, push_x, push_neg;
   logic signed [PEN_W-1:0]  sel_pen, sel_pos, sel_q, pos_sum, q_sum;
   logic signed [CTR_W-1:0]  sel_qmax, sel_qmin, q_new;
   logic signed [POS_W-1:0]  pos_new;

   // centre of the requested box, at centre width
   assign ofs_x    = $signed({{(CTR_W-OFF_W){req_off_x[OFF_W-1]}}, req_off_x});
   assign ofs_y    = $signed({{(CTR_W-OFF_W){req_off_y[OFF_W-1]}}, req_off_y});
   assign ctr_x_in = $signed({{(CTR_W-POS_W){req_pos_x[POS_W-1]}}, req_pos_x}) + ofs_x;
   assign ctr_y_in = $signed({{(CTR_W-POS_W){req_pos_y[POS_W-1]}}, req_pos_y}) + ofs_y;

   // table write: slot write or clear, or one entry of the clearing pass
   always_comb begin
      wr_entry     = '0;
      wr_entry.vld = dp_cmd.wr && dp_cmd.wr_vld;
      wr_entry.cx  = ctr_x_in;
      wr_entry.cy  = ctr_y_in;
      wr_entry.hx  = req_half_x;
      wr_entry.hy  = req_half_y;
   end

   assign wr_en   = dp_cmd.wr || dp_cmd.wipe;
   assign wr_addr = dp_cmd.wipe ? idx[AW-1:0] : AW'(req_slot);

   aabb_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (STATIC_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (idx[AW-1:0]),
      .rd_data (rd_entry)
   );

   // centre differences against the corrected dynamic centre
   assign dx_in  = $signed({rd_entry.cx[CTR_W-1], rd_entry.cx}) - $signed({qx_ff[CTR_W-1], qx_ff});
   assign dy_in  = $signed({rd_entry.cy[CTR_W-1], rd_entry.cy}) - $signed({qy_ff[CTR_W-1], qy_ff});
   assign hsx_in = {1'b0, hx_ff} + {1'b0, rd_entry.hx};
   assign hsy_in = {1'b0, hy_ff} + {1'b0, rd_entry.hy};

   // penetration: half extent sum minus absolute difference
   assign penx_in = dx_ff[DIFF_W-1]
      ? $signed({{(PEN_W-HSUM_W){1'b0}}, hsx_ff}) + $signed({dx_ff[DIFF_W-1], dx_ff})
      : $signed({{(PEN_W-HSUM_W){1'b0}}, hsx_ff}) - $signed({dx_ff[DIFF_W-1], dx_ff});
   assign peny_in = dy_ff[DIFF_W-1]
      ? $signed({{(PEN_W-HSUM_W){1'b0}}, hsy_ff}) + $signed({dy_ff[DIFF_W-1], dy_ff})
      : $signed({{(PEN_W-HSUM_W){1'b0}}, hsy_ff}) - $signed({dy_ff[DIFF_W-1], dy_ff});

   // axis choice, shared push adder and saturation
   assign overlap  = vld_b_ff && !penx_ff[PEN_W-1] && (penx_ff != '0) &&
                     !peny_ff[PEN_W-1] && (peny_ff != '0);
   assign push_x   = (penx_ff < peny_ff);
   assign push_neg = push_x ? sx_ff : sy_ff;
   assign sel_pen  = push_x ? penx_ff : peny_ff;
   assign sel_pos  = push_x ? $signed({{(PEN_W-POS_W){px_ff[POS_W-1]}}, px_ff})
                            : $signed({{(PEN_W-POS_W){py_ff[POS_W-1]}}, py_ff});
   assign sel_q    = push_x ? $signed({{(PEN_W-CTR_W){qx_ff[CTR_W-1]}}, qx_ff})
                            : $signed({{(PEN_W-CTR_W){qy_ff[CTR_W-1]}}, qy_ff});
   assign sel_qmax = push_x ? qx_max_ff : qy_max_ff;
   assign sel_qmin = push_x ? qx_min_ff : qy_min_ff;
   assign pos_sum  = push_neg ? sel_pos + sel_pen : sel_pos - sel_pen;
   assign q_sum    = push_neg ? sel_q + sel_pen : sel_q - sel_pen;

   always_comb begin
      if (pos_sum > PEN_POS_MAX) begin
         pos_new = PEN_POS_MAX[POS_W-1:0];
         q_new   = sel_qmax;
      end else if (pos_sum < PEN_POS_MIN) begin
         pos_new = PEN_POS_MIN[POS_W-1:0];
         q_new   = sel_qmin;
      end else begin
         pos_new = pos_sum[POS_W-1:0];
         q_new   = q_sum[CTR_W-1:0];
      end
   end

   // walk pipeline
   always_ff @(posedge clock) begin
      if (dp_cmd.diff) begin
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
         hsx_ff   <= hsx_in;
         hsy_ff   <= hsy_in;
         vld_a_ff <= rd_entry.vld;
      end
      if (dp_cmd.pen) begin
         penx_ff  <= penx_in;
         peny_ff  <= peny_in;
         sx_ff    <= dx_ff[DIFF_W-1];
         sy_ff    <= dy_ff[DIFF_W-1];
         vld_b_ff <= vld_a_ff;
      end
   end

   // dynamic box: capture on resolve, update on every overlap
   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         px_ff     <= req_pos_x;
         py_ff     <= req_pos_y;
         vx_ff     <= req_vel_x;
         vy_ff     <= req_vel_y;
         gnd_ff    <= req_ground_in;
         hit_ff    <= 1'b0;
         hx_ff     <= req_half_x;
         hy_ff     <= req_half_y;
         qx_ff     <= ctr_x_in;
         qy_ff     <= ctr_y_in;
         qx_max_ff <= CTR_POS_MAX + ofs_x;
         qx_min_ff <= CTR_POS_MIN + ofs_x;
         qy_max_ff <= CTR_POS_MAX + ofs_y;
         qy_min_ff <= CTR_POS_MIN + ofs_y;
      end else if (dp_cmd.upd && overlap) begin
         hit_ff <= 1'b1;
         if (push_x) begin
            px_ff <= pos_new;
            qx_ff <= q_new;
            vx_ff <= '0;
         end else begin
            py_ff <= pos_new;
            qy_ff <= q_new;
            vy_ff <= '0;
            if (sy_ff) begin
               gnd_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp_new_pos_x = px_ff;
   assign rsp_new_pos_y = py_ff;
   assign rsp_new_vel_x = vx_ff;
   assign rsp_new_vel_y = vy_ff;
   assign rsp_on_ground = gnd_ff;
   assign rsp_collided  = hit_ff;

endmodule

// ----- hdl/aabb_static_collision_resolver.sv -----
// top level of the static box collision resolver
//
//   channel   handshake                 payload
//   request   start in, busy out        req_cmd req_slot req_pos_* req_off_* req_half_*
//                                       req_vel_* req_ground_in
//   response  rsp_valid out (strobe)    rsp_new_pos_* rsp_new_vel_* rsp_on_ground
//                                       rsp_collided
//
// a transfer on the request side happens at a clock edge with start high and busy low.
// write and clear give no response.
// in a resolve each slot is read from the table ram and goes through difference,
// penetration and push-out steps before the next slot enters the difference step.
// the response strobe lasts one cycle; the receiver cannot stall it.
// after reset a clearing pass invalidates every table entry with busy high.
module aabb_static_collision_resolver import aabb_pkg::*; #(
   parameter int STATIC_SLOTS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_cmd,
   input  logic [5:0]               req_slot,
   input  logic signed [POS_W-1:0]  req_pos_x,
   input  logic signed [POS_W-1:0]  req_pos_y,
   input  logic signed [OFF_W-1:0]  req_off_x,
   input  logic signed [OFF_W-1:0]  req_off_y,
   input  logic        [HALF_W-1:0] req_half_x,
   input  logic        [HALF_W-1:0] req_half_y,
   input  logic signed [POS_W-1:0]  req_vel_x,
   input  logic signed [POS_W-1:0]  req_vel_y,
   input  logic                     req_ground_in,
   output logic                     rsp_valid,
   output logic signed [POS_W-1:0]  rsp_new_pos_x,
   output logic signed [POS_W-1:0]  rsp_new_pos_y,
   output logic signed [POS_W-1:0]  rsp_new_vel_x,
   output logic signed [POS_W-1:0]  rsp_new_vel_y,
   output logic                     rsp_on_ground,
   output logic                     rsp_collided
);

   localparam int CW = $clog2(STATIC_SLOTS + 1);

   dp_cmd_type    dp_cmd;
   logic [CW-1:0] idx;

   aabb_ctrl #(
      .STATIC_SLOTS (STATIC_SLOTS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_cmd   (req_cmd),
      .req_slot  (req_slot),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .dp_cmd    (dp_cmd),
      .idx       (idx)
   );

   aabb_dp #(
      .STATIC_SLOTS (STATIC_SLOTS)
   ) u_dp (
      .clock         (clock),
      .dp_cmd        (dp_cmd),
      .idx           (idx),
      .req_slot      (req_slot),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_off_x     (req_off_x),
      .req_off_y     (req_off_y),
      .req_half_x    (req_half_x),
      .req_half_y    (req_half_y),
      .req_vel_x     (req_vel_x),
      .req_vel_y     (req_vel_y),
      .req_ground_in (req_ground_in),
      .rsp_new_pos_x (rsp_new_pos_x),
      .rsp_new_pos_y (rsp_new_pos_y),
      .rsp_new_vel_x (rsp_new_vel_x),
      .rsp_new_vel_y (rsp_new_vel_y),
      .rsp_on_ground (rsp_on_ground),
      .rsp_collided  (rsp_collided)
   );

   // a resolve transfer keeps the block busy in the next cycle
   a_resolve_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd == CMD_RESOLVE) |=> busy)
      else $error("resolve accepted but block not busy");

   // the response strobe lasts exactly one cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   // no request transfer while a response is shown
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response shown while block idle");

   // table writes from requests happen only on an idle block
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.wr |-> (!busy && !dp_cmd.wipe))
      else $error("table write outside an idle cycle");

endmodule
